### rtl/lzwd_pkg.sv
// lzwd_pkg: shared types and constants for the lz window decompressor
// used by lzwd_ctrl, lzwd_datapath and lz_window_decompressor; no dependencies

package lzwd_pkg;

	localparam int unsigned WINDOW_DEPTH_DEF = 4096;

	localparam int unsigned COUNT_W = 24;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFF_FFFF;

	localparam int unsigned FLAG_W = 16;
	localparam logic [4:0] FLAG_COUNT = 5'h10;

	localparam int unsigned DIST_W = 12;
	localparam logic [DIST_W-1:0] DIST_MIN_FIELD = 12'd2;
	localparam logic [4:0] LEN_BIAS = 5'd3;

	localparam logic OP_CMD = 1'b0;
	localparam logic OP_LIT = 1'b1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_COPY
	} state_t;

	typedef struct packed {
		logic accept;
		logic emit;
		logic load;
	} ctl_cmd_t;

	typedef struct packed {
		logic res_full;
		logic match_ok;
		logic copy_last;
	} dp_status_t;

endpackage

### rtl/lz_window_decompressor.sv
// lz_window_decompressor: top level of the lz window decoder
// results: a non-copying item's result is registered at the accepting edge; a pair's copy
// bytes follow one per cycle through the single history write port, holding off new items
// throughput: one item per cycle for control words and literals; both pause on res_stall
// reset: arst_n clears control, flags, counts and the error flag; history is not cleared
// depends on lzwd_pkg, lzwd_ctrl, lzwd_datapath

module lz_window_decompressor #(
	parameter int unsigned WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lzwd_pkg::COUNT_W-1:0]  cfg_wr_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          op,
	input  logic [lzwd_pkg::FLAG_W-1:0]   cmd_word,
	input  logic [7:0]                    literal,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [7:0]                    out_byte,
	output logic                          byte_valid,
	output logic                          last,
	output logic                          next_op,
	output logic                          done_res,
	output logic                          error
);

	lzwd_pkg::ctl_cmd_t   cmd;
	lzwd_pkg::dp_status_t status;

	lzwd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.res_stall  (res_stall),
		.status     (status),
		.cmd        (cmd)
	);

	lzwd_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.op          (op),
		.cmd_word    (cmd_word),
		.literal     (literal),
		.res_stall   (res_stall),
		.res_valid   (res_valid),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last        (last),
		.next_op     (next_op),
		.done_res    (done_res),
		.error       (error)
	);

endmodule

### rtl/lzwd_ctrl.sv
// lzwd_ctrl: sequencer for item acceptance and match copy beats
// depends on lzwd_pkg

module lzwd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  res_stall,
	input  lzwd_pkg::dp_status_t  status,
	output lzwd_pkg::ctl_cmd_t    cmd
);

	lzwd_pkg::state_t state_q;
	lzwd_pkg::state_t state_nxt;
	logic can_load;

	assign can_load = !status.res_full || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lzwd_pkg::ST_IDLE: begin
				if (item_valid && can_load && status.match_ok) begin
					state_nxt = lzwd_pkg::ST_COPY;
				end
			end
			lzwd_pkg::ST_COPY: begin
				if (can_load && status.copy_last) begin
					state_nxt = lzwd_pkg::ST_IDLE;
				end
			end
			default: state_nxt = lzwd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		cmd = '0;
		unique case (state_q)
			lzwd_pkg::ST_IDLE: begin
				item_stall = !can_load;
				cmd.accept = item_valid && can_load;
				cmd.load = item_valid && can_load && !status.match_ok;
			end
			lzwd_pkg::ST_COPY: begin
				cmd.emit = can_load;
				cmd.load = can_load;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

endmodule

### rtl/lzwd_datapath.sv
// lzwd_datapath: history window, flag and count state, match pointers, result register
// depends on lzwd_pkg; driven by lzwd_ctrl

module lzwd_datapath #(
	parameter int unsigned WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lzwd_pkg::ctl_cmd_t                cmd,
	output lzwd_pkg::dp_status_t              status,
	input  logic                              cfg_wr_en,
	input  logic [lzwd_pkg::COUNT_W-1:0]      cfg_wr_data,
	input  logic                              op,
	input  logic [lzwd_pkg::FLAG_W-1:0]       cmd_word,
	input  logic [7:0]                        literal,
	input  logic                              res_stall,
	output logic                              res_valid,
	output logic [7:0]                        out_byte,
	output logic                              byte_valid,
	output logic                              last,
	output logic                              next_op,
	output logic                              done_res,
	output logic                              error
);

	localparam int unsigned AW = $clog2(WINDOW_DEPTH);
	localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_DEPTH - 1);
	localparam logic [AW:0] DEPTH_EXT = (AW+1)'(WINDOW_DEPTH);

	logic [7:0] hist_mem [WINDOW_DEPTH];
	logic [7:0] rdata_q;

	logic [lzwd_pkg::COUNT_W-1:0] out_len_q;
	logic [lzwd_pkg::COUNT_W-1:0] count_q;
	logic [lzwd_pkg::FLAG_W-1:0]  flag_bits_q;
	logic [4:0]                   flags_left_q;
	logic                         err_q;

	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [4:0]    copy_left_q;
	logic          dist1_q;
	logic [7:0]    last_wr_q;

	logic       res_valid_q;
	logic [7:0] res_byte_q;
	logic       res_bvalid_q;
	logic       res_last_q;

	logic done_w;
	logic want_lit;
	logic bad_kind;
	logic load_flags;
	logic is_lit;
	logic is_match;
	logic dist_bad;
	logic match_ok;
	logic set_err;
	logic [lzwd_pkg::DIST_W-1:0] low;
	logic [lzwd_pkg::DIST_W-1:0] back_dist;
	logic [4:0] len;
	logic [lzwd_pkg::COUNT_W:0] count_sum;
	logic [lzwd_pkg::COUNT_W-1:0] count_sat;
	logic [AW:0] wp_ext;
	logic [AW:0] dist_ext;
	logic [AW:0] rp_start_ext;
	logic [AW-1:0] rp_start;
	logic [AW-1:0] rp_inc;
	logic [AW-1:0] wp_inc;
	logic [AW-1:0] raddr;
	logic [7:0] copy_byte;
	logic       mem_we;
	logic [7:0] mem_wdata;

	// live status
	assign done_w = count_q >= out_len_q;
	assign want_lit = !err_q && !done_w && (flags_left_q != 5'd0) && !flag_bits_q[lzwd_pkg::FLAG_W-1];

	// item decode
	assign low = cmd_word[lzwd_pkg::DIST_W-1:0];
	assign back_dist = low - 12'd1;
	assign len = {1'b0, cmd_word[lzwd_pkg::FLAG_W-1:lzwd_pkg::DIST_W]} + lzwd_pkg::LEN_BIAS;
	assign bad_kind = !err_q && (done_w || (op != want_lit));
	assign load_flags = !err_q && !bad_kind && (flags_left_q == 5'd0);
	assign is_lit = !err_q && !bad_kind && (flags_left_q != 5'd0) && (op == lzwd_pkg::OP_LIT);
	assign is_match = !err_q && !bad_kind && (flags_left_q != 5'd0) && (op == lzwd_pkg::OP_CMD);
	assign dist_bad = (low < lzwd_pkg::DIST_MIN_FIELD)
		|| (lzwd_pkg::COUNT_W'(back_dist) > count_q);
	assign match_ok = is_match && !dist_bad;
	assign set_err = bad_kind || (is_match && dist_bad);

	// count after an item, saturating
	always_comb begin
		if (is_lit) begin
			count_sum = {1'b0, count_q} + 25'd1;
		end else begin
			count_sum = {1'b0, count_q} + 25'(len);
		end
		if (count_sum > {1'b0, lzwd_pkg::COUNT_MAX}) begin
			count_sat = lzwd_pkg::COUNT_MAX;
		end else begin
			count_sat = count_sum[lzwd_pkg::COUNT_W-1:0];
		end
	end

	// window pointers
	assign wp_ext = {1'b0, wp_q};
	assign dist_ext = (AW+1)'(back_dist);
	always_comb begin
		if (wp_ext >= dist_ext) begin
			rp_start_ext = wp_ext - dist_ext;
		end else begin
			rp_start_ext = wp_ext + DEPTH_EXT - dist_ext;
		end
	end
	assign rp_start = rp_start_ext[AW-1:0];
	assign rp_inc = (rp_q == PTR_LAST) ? '0 : rp_q + AW'(1);
	assign wp_inc = (wp_q == PTR_LAST) ? '0 : wp_q + AW'(1);

	always_comb begin
		priority if (cmd.accept) begin
			raddr = rp_start;
		end else if (cmd.emit) begin
			raddr = rp_inc;
		end else begin
			raddr = rp_q;
		end
	end

	// distance of one repeats the byte just written
	assign copy_byte = dist1_q ? last_wr_q : rdata_q;
	assign mem_we = cmd.emit || (cmd.accept && is_lit);
	assign mem_wdata = cmd.emit ? copy_byte : literal;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[wp_q] <= mem_wdata;
		end
		rdata_q <= hist_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_len_q    <= '0;
			count_q      <= '0;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			err_q        <= 1'b0;
			wp_q         <= '0;
			rp_q         <= '0;
			copy_left_q  <= '0;
			dist1_q      <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				out_len_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				if (set_err) begin
					err_q <= 1'b1;
				end
				if (load_flags) begin
					flag_bits_q  <= cmd_word;
					flags_left_q <= lzwd_pkg::FLAG_COUNT;
				end
				if (is_lit || match_ok) begin
					count_q      <= count_sat;
					flag_bits_q  <= {flag_bits_q[lzwd_pkg::FLAG_W-2:0], 1'b0};
					flags_left_q <= flags_left_q - 5'd1;
				end
				if (is_lit) begin
					wp_q <= wp_inc;
				end
				if (match_ok) begin
					rp_q        <= rp_start;
					copy_left_q <= len;
					dist1_q     <= (low == lzwd_pkg::DIST_MIN_FIELD);
				end
			end
			if (cmd.emit) begin
				wp_q        <= wp_inc;
				rp_q        <= rp_inc;
				copy_left_q <= copy_left_q - 5'd1;
			end
			if (cmd.load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			last_wr_q <= mem_wdata;
		end
		if (cmd.load) begin
			if (cmd.emit) begin
				res_byte_q   <= copy_byte;
				res_bvalid_q <= 1'b1;
				res_last_q   <= (copy_left_q == 5'd1);
			end else begin
				res_byte_q   <= is_lit ? literal : 8'd0;
				res_bvalid_q <= is_lit;
				res_last_q   <= 1'b1;
			end
		end
	end

	assign status.res_full  = res_valid_q;
	assign status.match_ok  = match_ok;
	assign status.copy_last = (copy_left_q == 5'd1);

	assign res_valid  = res_valid_q;
	assign out_byte   = res_byte_q;
	assign byte_valid = res_bvalid_q;
	assign last       = res_last_q;
	assign next_op    = want_lit;
	assign done_res   = done_w;
	assign error      = err_q;

`ifndef SYNTHESIS
	a_emit_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> copy_left_q != 5'd0)
		else $error("copy beat with no bytes left");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!res_valid_q || !res_stall))
		else $error("held result overwritten");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> count_q >= $past(count_q))
		else $error("output count went backwards");

	a_flags_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		flags_left_q <= lzwd_pkg::FLAG_COUNT)
		else $error("flag count out of range");
`endif

endmodule
